// ===== hdl/lmsf_pkg.sv =====
`timescale 1ns / 1ps

package lmsf_pkg;

  // Matrix geometry
  localparam int ROWS      = 5;
  localparam int COLS      = 5;
  localparam int LED_COUNT = ROWS * COLS;
  localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CNT_W     = 6;
  localparam int COLOR_W   = 24;

  // Counter value of the final LED of a send
  localparam logic [CNT_W-1:0] LAST_LED = CNT_W'(LED_COUNT - 1);

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_HRUN  = 3'd1,
    CMD_VRUN  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_SEND  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEND
  } state_t;

  // Access request from the sequencer to the pixel store
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [COLOR_W-1:0]   wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
    logic                 last;
    logic                 clear;
  } mem_req_t;

  // Map an in-range (row, column) to its chain position
  function automatic logic [ADDR_W-1:0] chain_index(input logic [2:0] row,
                                                    input logic [2:0] col);
    logic [5:0] c6;
    logic [5:0] r6;
    logic [5:0] idx6;
    c6   = row[0] ? {3'b000, col} : (6'(COLS - 1) - {3'b000, col});
    r6   = 6'(ROWS - 1) - {3'b000, row};
    idx6 = 6'(6'(COLS) * r6) + c6;
    return idx6[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/lmsf_ram.sv =====
`timescale 1ns / 1ps

module lmsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 25,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lmsf_ctrl.sv =====
`timescale 1ns / 1ps

module lmsf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [2:0]              in_command,
  input  logic [2:0]              in_row,
  input  logic [2:0]              in_column,
  input  logic [3:0]              in_run_length,
  input  logic [7:0]              in_red,
  input  logic [7:0]              in_green,
  input  logic [7:0]              in_blue,
  output logic                    busy,
  output lmsf_pkg::mem_req_t      req
);

  lmsf_pkg::state_t state_r, state_nxt;
  logic [lmsf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]                   row_r, row_nxt;
  logic [2:0]                   col_r, col_nxt;
  logic [3:0]                   len_r, len_nxt;
  logic                         vert_r, vert_nxt;
  logic [lmsf_pkg::COLOR_W-1:0] color_r, color_nxt;

  logic [4:0] cur_row;
  logic [4:0] cur_col;
  logic       in_range;
  logic       accept;

  assign accept = start && (state_r == lmsf_pkg::ST_IDLE);
  assign busy   = (state_r != lmsf_pkg::ST_IDLE);

  assign cur_row  = vert_r ? ({2'b00, row_r} + {1'b0, cnt_r[3:0]}) : {2'b00, row_r};
  assign cur_col  = vert_r ? {2'b00, col_r} : ({2'b00, col_r} + {1'b0, cnt_r[3:0]});
  assign in_range = (cur_row < 5'(lmsf_pkg::ROWS)) && (cur_col < 5'(lmsf_pkg::COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmsf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    len_r   <= len_nxt;
    vert_r  <= vert_nxt;
    color_r <= color_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    len_nxt   = len_r;
    vert_nxt  = vert_r;
    color_nxt = color_r;
    req       = '0;
    req.wdata = color_r;
    req.waddr = lmsf_pkg::chain_index(cur_row[2:0], cur_col[2:0]);
    req.raddr = cnt_r[lmsf_pkg::ADDR_W-1:0];

    unique case (state_r)
      lmsf_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          row_nxt   = in_row;
          col_nxt   = in_column;
          color_nxt = {in_red, in_green, in_blue};
          case (in_command) inside
            lmsf_pkg::CMD_WRITE: begin
              len_nxt   = 4'd1;
              vert_nxt  = 1'b0;
              state_nxt = lmsf_pkg::ST_DRAW;
            end
            lmsf_pkg::CMD_HRUN, lmsf_pkg::CMD_VRUN: begin
              len_nxt  = in_run_length;
              vert_nxt = (in_command == lmsf_pkg::CMD_VRUN);
              if (in_run_length != 4'd0) begin
                state_nxt = lmsf_pkg::ST_DRAW;
              end
            end
            lmsf_pkg::CMD_CLEAR: begin
              req.clear = 1'b1;
            end
            lmsf_pkg::CMD_SEND: begin
              state_nxt = lmsf_pkg::ST_SEND;
            end
            default: begin
            end
          endcase
        end
      end
      lmsf_pkg::ST_DRAW: begin
        // paint one pixel a cycle, drop those off the matrix
        req.we  = in_range;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == len_r - 4'd1) begin
          state_nxt = lmsf_pkg::ST_IDLE;
        end
      end
      lmsf_pkg::ST_SEND: begin
        req.re   = 1'b1;
        req.last = (cnt_r == lmsf_pkg::LAST_LED);
        cnt_nxt  = cnt_r + 1'b1;
        if (req.last) begin
          state_nxt = lmsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmsf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/led_matrix_serpentine_framebuffer.sv =====
`timescale 1ns / 1ps

// Frame store for a serpentine-wired LED matrix (ROWS x COLS from the package).
//
// Command channel: present a command on the in_* ports with start high; it is
// taken at the rising edge where start is high and busy is low. Busy rises
// the cycle after a write, a run or a send is taken and stays high while the
// command runs.
//   write pixel : one pixel painted, then back to idle.
//   run of n    : n pixels painted, one per cycle (off-matrix
//                 pixels are dropped); a run of zero never raises busy.
//   clear       : done at the accepting edge, busy stays low.
//   send        : all ROWS*COLS pixels, one pixel store read per cycle.
// Result channel: a send produces ROWS*COLS beats in chain order, one per
// cycle with out_strobe high, after the sequencer state and the store read
// are each registered; out_last marks the final beat. The receiver cannot
// stall, so every beat is taken the cycle it is shown. Throughput is set by
// the single read port of the pixel store: one LED per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears the
// per-pixel valid bits, so the whole frame reads as black; the store itself
// is never swept.
module led_matrix_serpentine_framebuffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [2:0] in_row,
  input  logic [2:0] in_column,
  input  logic [3:0] in_run_length,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_strobe,
  output logic [5:0] out_led_index,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic [7:0] out_blue,
  output logic       out_last
);

  lmsf_pkg::mem_req_t                req;
  logic [lmsf_pkg::COLOR_W-1:0]      rdata;
  logic [lmsf_pkg::LED_COUNT-1:0]    valid_r;

  // read stage: tracks the beat whose data the store returns this cycle
  logic                              rd_vld_r;
  logic                              rd_last_r;
  logic                              rd_hit_r;
  logic [lmsf_pkg::ADDR_W-1:0]       rd_idx_r;

  lmsf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_command    (in_command),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_run_length (in_run_length),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .busy          (busy),
    .req           (req)
  );

  lmsf_ram #(
    .WIDTH (lmsf_pkg::COLOR_W),
    .DEPTH (lmsf_pkg::LED_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  // Valid bits: an entry never written since reset or clear reads as black.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  // Align beat control with the registered store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= req.re;
      rd_last_r <= req.re && req.last;
    end
    rd_idx_r <= req.raddr;
    rd_hit_r <= valid_r[req.raddr];
  end

  assign out_strobe    = rd_vld_r;
  assign out_last      = rd_last_r;
  assign out_led_index = 6'(rd_idx_r);
  // store word is {red, green, blue}; hold black for never-written entries
  assign out_red       = rd_hit_r ? rdata[23:16] : 8'd0;
  assign out_green     = rd_hit_r ? rdata[15:8]  : 8'd0;
  assign out_blue      = rd_hit_r ? rdata[7:0]   : 8'd0;

  // A beat only follows a cycle in which the send was running.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a running send");

  a_last_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last flag outside a beat");

  // A frame goes out as one unbroken burst of ascending indexes.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=>
      (out_strobe && (out_led_index == $past(out_led_index) + 6'd1)))
    else $error("send burst broken or out of order");

  a_send_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == lmsf_pkg::CMD_SEND)) |=> busy)
    else $error("send taken but sequencer idle");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Frame store testbench: directed script first, then random drawing with
// frame sends. A local copy of the frame predicts the beats of every send but the script's fixed ones.
module tb_top;

  // Spare command codes: the block must ignore them
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int LEDS = lmsf_pkg::LED_COUNT;
  localparam int NROW = lmsf_pkg::ROWS;
  localparam int NCOL = lmsf_pkg::COLS;

  localparam int SCRIPT_ROWS  = 25;
  localparam int RANDOM_ITEMS = 185;
  localparam int CALM_FIRST   = 80;   // no sender idling from this item ...
  localparam int CALM_LAST    = 140;  // ... up to but not including this one
  localparam int PAUSE_AT     = 110;  // hold off here until the frame is out
  localparam int DRAIN_CYCLES = 8;    // extra wait once no beat is due
  localparam int STALL_LIMIT  = 500;  // watchdog limit with neither a command nor a beat
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] row;
    logic [2:0] column;
    logic [3:0] run_length;
    rgb_t       color;
  } draw_op_t;

  // One line of the directed script. A send with fixed set expects every
  // LED to show fill; all other lines go through the frame predictor.
  typedef struct packed {
    draw_op_t op;
    logic     fixed;
    rgb_t     fill;
  } script_row_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last;
  } led_beat_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_command;
  logic [2:0] in_row;
  logic [2:0] in_column;
  logic [3:0] in_run_length;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       out_strobe;
  logic [5:0] out_led_index;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_blue;
  logic       out_last;

  // Predicted frame in chain order, and the LED beats still to come
  rgb_t      frame_q [LEDS];
  led_beat_t led_beats_due [$];
  int        mismatches;
  int        stall_cnt;

  led_matrix_serpentine_framebuffer u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_row       (in_row),
    .in_column    (in_column),
    .in_run_length(in_run_length),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_strobe   (out_strobe),
    .out_led_index(out_led_index),
    .out_green    (out_green),
    .out_red      (out_red),
    .out_blue     (out_blue),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------

  function automatic void clear_frame();
    for (int i = 0; i < LEDS; i++) frame_q[i] = '0;
  endfunction

  // Paint one pixel; drop it when it falls off the matrix. Rows count from
  // the top but the chain starts at the bottom row, and even rows run right
  // to left.
  function automatic void paint_led(int row, int col, rgb_t color);
    int pos;
    if (row >= NROW || col >= NCOL) return;
    pos = NCOL * (NROW - 1 - row) + ((row % 2 == 0) ? NCOL - 1 - col : col);
    frame_q[pos] = color;
  endfunction

  // Apply one accepted command to the frame; a send queues one beat per LED
  function automatic void frame_predict(draw_op_t op);
    led_beat_t b;
    case (op.command)
      lmsf_pkg::CMD_WRITE: paint_led(op.row, op.column, op.color);
      lmsf_pkg::CMD_HRUN:
        for (int i = 0; i < op.run_length; i++)
          paint_led(op.row, op.column + i, op.color);
      lmsf_pkg::CMD_VRUN:
        for (int i = 0; i < op.run_length; i++)
          paint_led(op.row + i, op.column, op.color);
      lmsf_pkg::CMD_CLEAR: clear_frame();
      lmsf_pkg::CMD_SEND: begin
        for (int i = 0; i < LEDS; i++) begin
          b.led_index = 6'(i);
          b.green     = frame_q[i].green;
          b.red       = frame_q[i].red;
          b.blue      = frame_q[i].blue;
          b.last      = (i == LEDS - 1);
          led_beats_due.push_back(b);
        end
      end
      default: ;  // spare codes leave the frame alone
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------

  function automatic script_row_t draw(logic [2:0] cmd, int row, int col, int len,
                                       rgb_t color);
    script_row_t r;
    r.op.command    = cmd;
    r.op.row        = 3'(row);
    r.op.column     = 3'(col);
    r.op.run_length = 4'(len);
    r.op.color      = color;
    r.fixed         = 1'b0;
    r.fill          = '0;
    return r;
  endfunction

  function automatic script_row_t fill_send(rgb_t fill);
    script_row_t r;
    r       = draw(lmsf_pkg::CMD_SEND, 0, 0, 0, 24'h0);
    r.fixed = 1'b1;
    r.fill  = fill;
    return r;
  endfunction

  function automatic script_row_t script(int k);
    script_row_t r;
    case (k)
      0:  r = fill_send(24'h000000);                     // frame is black after reset
      1:  r = draw(lmsf_pkg::CMD_WRITE, 0, 0, 0, 24'hFF0000);   // top left, even row flips
      2:  r = draw(lmsf_pkg::CMD_WRITE, NROW - 1, NCOL - 1, 0, 24'h00FF00);
      3:  r = draw(lmsf_pkg::CMD_WRITE, 1, 0, 0, 24'h0000FF);   // odd row runs left to right
      4:  r = draw(lmsf_pkg::CMD_WRITE, 7, 7, 0, 24'hFFFFFF);   // off the matrix
      5:  r = draw(lmsf_pkg::CMD_WRITE, 2, 5, 0, 24'hFFFFFF);   // column just past the edge
      6:  r = draw(lmsf_pkg::CMD_HRUN, 3, 2, 8, 24'h123456);    // run leaves the right edge
      7:  r = draw(lmsf_pkg::CMD_HRUN, 5, 0, 8, 24'hABCDEF);    // row off the matrix
      8:  r = draw(lmsf_pkg::CMD_HRUN, 0, 7, 15, 24'hFFFFFF);   // start column off the matrix
      9:  r = draw(lmsf_pkg::CMD_HRUN, 0, 0, 0, 24'hFFFFFF);    // zero length paints nothing
      10: r = draw(lmsf_pkg::CMD_VRUN, 2, 1, 15, 24'h5A5A5A);   // longest run, leaves the bottom
      11: r = draw(lmsf_pkg::CMD_VRUN, 0, 6, 8, 24'hFFFFFF);    // column off the matrix
      12: r = draw(CMD_SPARE5, 0, 0, 8, 24'hFFFFFF);
      13: r = draw(lmsf_pkg::CMD_SEND, 0, 0, 0, 24'h0);
      14: r = draw(lmsf_pkg::CMD_CLEAR, 7, 7, 15, 24'hFFFFFF);  // clear never raises busy
      15: r = fill_send(24'h000000);
      16: r = draw(lmsf_pkg::CMD_VRUN, 0, 0, 8, 24'hFFFFFF);    // paint every column white
      17: r = draw(lmsf_pkg::CMD_VRUN, 0, 1, 8, 24'hFFFFFF);
      18: r = draw(lmsf_pkg::CMD_VRUN, 0, 2, 8, 24'hFFFFFF);
      19: r = draw(lmsf_pkg::CMD_VRUN, 0, 3, 8, 24'hFFFFFF);
      20: r = draw(lmsf_pkg::CMD_VRUN, 0, 4, 8, 24'hFFFFFF);
      21: r = fill_send(24'hFFFFFF);
      22: r = draw(CMD_SPARE6, 7, 7, 15, 24'h000000);
      23: r = draw(lmsf_pkg::CMD_WRITE, 0, 4, 0, 24'h010203);
      default: r = draw(lmsf_pkg::CMD_SEND, 0, 0, 0, 24'h0);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------

  // Keep most coordinates and run lengths in range so runs land on the
  // frame; the rest reach the full width of each field.
  function automatic draw_op_t random_op();
    draw_op_t op;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op.command = lmsf_pkg::CMD_WRITE;
    else if (pick < 55) op.command = lmsf_pkg::CMD_HRUN;
    else if (pick < 74) op.command = lmsf_pkg::CMD_VRUN;
    else if (pick < 78) op.command = lmsf_pkg::CMD_CLEAR;
    else if (pick < 94) op.command = lmsf_pkg::CMD_SEND;
    else begin
      case ($urandom_range(0, 2))
        0:       op.command = CMD_SPARE5;
        1:       op.command = CMD_SPARE6;
        default: op.command = CMD_SPARE7;
      endcase
    end
    op.row    = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NROW - 1))
                                             : 3'($urandom);
    op.column = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NCOL - 1))
                                             : 3'($urandom);
    op.run_length = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom);
    op.color  = 24'($urandom);
    return op;
  endfunction

  // ---------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------

  // Present one command and hold it until the edge that takes it. Leave
  // start high on return so back-to-back commands need no extra edge.
  task automatic issue_op(input draw_op_t op);
    in_command    <= op.command;
    in_row        <= op.row;
    in_column     <= op.column;
    in_run_length <= op.run_length;
    in_red        <= op.color.red;
    in_green      <= op.color.green;
    in_blue       <= op.color.blue;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Idle the sender now and then; scramble the command ports while start
  // is low, since the block must not look at them.
  task automatic maybe_idle();
    if ($urandom_range(0, 99) >= 8) return;
    start         <= 1'b0;
    in_command    <= 3'($urandom);
    in_row        <= 3'($urandom);
    in_column     <= 3'($urandom);
    in_run_length <= 4'($urandom);
    in_red        <= 8'($urandom);
    in_green      <= 8'($urandom);
    in_blue       <= 8'($urandom);
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Drop start and wait until every LED beat of every send has come out
  task automatic drain_frames();
    start <= 1'b0;
    while (led_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    script_row_t row_now;
    draw_op_t    op;
    led_beat_t   b;
    int          taken;
    bit          paused;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_command    <= lmsf_pkg::CMD_WRITE;
    in_row        <= '0;
    in_column     <= '0;
    in_run_length <= '0;
    in_red        <= '0;
    in_green      <= '0;
    in_blue       <= '0;
    clear_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the script. Fixed sends expect a uniform frame read straight
    // off the script; everything else goes through the predictor.
    for (int k = 0; k < SCRIPT_ROWS; k++) begin
      row_now = script(k);
      maybe_idle();
      issue_op(row_now.op);
      if (row_now.fixed) begin
        for (int i = 0; i < LEDS; i++) begin
          b.led_index = 6'(i);
          b.green     = row_now.fill.green;
          b.red       = row_now.fill.red;
          b.blue      = row_now.fill.blue;
          b.last      = (i == LEDS - 1);
          led_beats_due.push_back(b);
        end
      end else begin
        frame_predict(row_now.op);
      end
    end
    drain_frames();

    // Random part, spare codes included in the item total. Keep the
    // sender busy without gaps through a middle stretch.
    taken  = 0;
    paused = 1'b0;
    while (taken < RANDOM_ITEMS) begin
      op = random_op();
      if (!paused && taken == PAUSE_AT) begin
        drain_frames();
        paused = 1'b1;
      end
      if (taken < CALM_FIRST || taken >= CALM_LAST) maybe_idle();
      issue_op(op);
      frame_predict(op);
      taken++;
    end

    drain_frames();
    if (mismatches == 0 && led_beats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // LED beat checker: every strobed beat must match the oldest one due
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    led_beat_t want;
    if (rst_n && out_strobe) begin
      if (led_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: beat with nothing due: idx=%0d g=%02h r=%02h b=%02h last=%0b",
                   out_led_index, out_green, out_red, out_blue, out_last);
      end else begin
        want = led_beats_due.pop_front();
        if (out_led_index !== want.led_index || out_green !== want.green ||
            out_red !== want.red || out_blue !== want.blue || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: want idx=%0d g=%02h r=%02h b=%02h last=%0b, ",
                      "got idx=%0d g=%02h r=%02h b=%02h last=%0b"},
                     want.led_index, want.green, want.red, want.blue, want.last,
                     out_led_index, out_green, out_red, out_blue, out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: end the run if neither a command nor a beat moves for long
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    mismatches = 0;
    stall_cnt  = 0;
  end

endmodule
